[design/trfs_pkg.sv]
package trfs_pkg;

    // Record framing
    localparam int LENGTH_BITS      = 32;
    localparam int MAX_VARINT_BYTES = 10;
    localparam int VIDX_W           = $clog2(MAX_VARINT_BYTES);

    localparam logic [31:0] LEN_MASK =
        (LENGTH_BITS >= 32) ? 32'hffff_ffff : ((32'd1 << LENGTH_BITS) - 32'd1);

    typedef logic [VIDX_W-1:0] vidx_t;

    // Input word command
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Payload encodings
    localparam logic [2:0] ENC_BYTE    = 3'd0;
    localparam logic [2:0] ENC_VARUINT = 3'd1;
    localparam logic [2:0] ENC_VARSINT = 3'd2;
    localparam logic [2:0] ENC_FIXED4  = 3'd3;
    localparam logic [2:0] ENC_FIXED8  = 3'd4;
    localparam logic [2:0] ENC_FIXED12 = 3'd5;
    localparam logic [2:0] ENC_FIXED16 = 3'd6;
    localparam logic [2:0] ENC_SIZED   = 3'd7;

    // Error codes
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_OVERFLOW    = 4'd1;
    localparam logic [3:0] ERR_NONCANON    = 4'd2;
    localparam logic [3:0] ERR_OVERLONG    = 4'd3;
    localparam logic [3:0] ERR_ID_ZERO     = 4'd4;
    localparam logic [3:0] ERR_ID_WIDE     = 4'd5;
    localparam logic [3:0] ERR_ID_ORDER    = 4'd6;
    localparam logic [3:0] ERR_SIZED_PAST  = 4'd7;
    localparam logic [3:0] ERR_TRUNCATED   = 4'd8;

    // Outcome of feeding one byte to the varint decoder
    typedef enum logic [1:0] {
        VS_PEND,
        VS_DONE,
        VS_ERR
    } vstat_t;

    typedef struct packed {
        vstat_t      status;
        logic [3:0]  err;
        logic [63:0] acc;
        vidx_t       idx;
    } vstep_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] record_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic        header_done;
        logic [31:0] cur_id;
        logic [2:0]  encoding;
        logic        payload_done;
        logic [63:0] value;
        logic        record_done;
        logic [3:0]  error_code;
    } result_t;

    // Byte count of the fixed-size encodings
    function automatic logic [4:0] fixed_len(input logic [2:0] enc);
        logic [4:0] len;
        unique case (enc)
            ENC_BYTE:    len = 5'd1;
            ENC_FIXED4:  len = 5'd4;
            ENC_FIXED8:  len = 5'd8;
            ENC_FIXED12: len = 5'd12;
            ENC_FIXED16: len = 5'd16;
            default:     len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

[design/tagged_record_field_scanner.sv]
// Tagged record field scanner.
// Input channel (s_*): one word per record byte, or a begin word (s_cmd = 0)
// carrying the record length. Each accepted word produces exactly one
// result word on the output channel (m_*): header/payload/record completion
// flags, current field id and encoding, decoded value and sticky error code.
// Path: an accepted word is first held in the input register; its result
// then moves into the result register and is presented on m_* when the
// result register is free.
// Throughput: one word per cycle while m_ready is high; the whole step for
// a byte is a single pass through the varint merge, id checks and counters
// between the input register and the result register.
// Stall: when m_ready is low, the result register holds and the input
// register keeps one more word; s_ready drops only when both are full.
// Reset (aresetn low, synchronous): both registers empty, no record open,
// field id, encoding and error read as zero; data words before the first
// begin are ignored.
module tagged_record_field_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [31:0] s_record_length,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_header_done,
    output logic [31:0] m_cur_id,
    output logic [2:0]  m_encoding,
    output logic        m_payload_done,
    output logic [63:0] m_value,
    output logic        m_record_done,
    output logic [3:0]  m_error_code
);

    logic               in_valid_reg;
    trfs_pkg::item_t    in_item_reg;
    logic               out_valid_reg;
    trfs_pkg::result_t  out_res_reg;
    trfs_pkg::result_t  res_next;
    logic               advance;

    // Input word moves to the result register when that is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    trfs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_item_reg),
        .result  (res_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_item_reg.cmd           <= s_cmd;
            in_item_reg.record_length <= s_record_length;
            in_item_reg.data_byte     <= s_data_byte;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_header_done  = out_res_reg.header_done;
    assign m_cur_id       = out_res_reg.cur_id;
    assign m_encoding     = out_res_reg.encoding;
    assign m_payload_done = out_res_reg.payload_done;
    assign m_value        = out_res_reg.value;
    assign m_record_done  = out_res_reg.record_done;
    assign m_error_code   = out_res_reg.error_code;

    // An empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with empty result register");

    // A clean record end never carries an error
    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_record_done) |-> (m_error_code == trfs_pkg::ERR_NONE))
        else $error("record_done with error code");

    // One byte cannot finish both a header and a payload
    a_hdr_pay_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_header_done && m_payload_done))
        else $error("header_done and payload_done together");

    // Completion flags only come with no error
    a_hdr_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_header_done || m_payload_done))
            |-> (m_error_code == trfs_pkg::ERR_NONE))
        else $error("field completion reported with error");

endmodule

[design/trfs_varint.sv]
module trfs_varint (
    input  trfs_pkg::vidx_t  idx_in,
    input  logic [63:0]      acc_in,
    input  logic [7:0]       data_in,
    output trfs_pkg::vstep_t step
);

    logic [6:0] payload;
    logic [6:0] shamt;
    logic       last_byte;

    assign payload   = data_in[6:0];
    // shift = 7 * index
    assign shamt     = {idx_in, 3'b000} - {3'b000, idx_in};
    assign last_byte = (idx_in == trfs_pkg::VIDX_W'(trfs_pkg::MAX_VARINT_BYTES - 1));

    // One LEB128 byte: merge payload, then classify
    always_comb begin
        step.acc    = acc_in | (64'(payload) << shamt);
        step.idx    = idx_in;
        step.err    = trfs_pkg::ERR_NONE;
        step.status = trfs_pkg::VS_PEND;
        if (last_byte && (payload > 7'd1)) begin
            step.status = trfs_pkg::VS_ERR;
            step.err    = trfs_pkg::ERR_OVERFLOW;
        end else if (!data_in[7]) begin
            if ((idx_in != '0) && (payload == 7'd0)) begin
                step.status = trfs_pkg::VS_ERR;
                step.err    = trfs_pkg::ERR_NONCANON;
            end else begin
                step.status = trfs_pkg::VS_DONE;
            end
        end else if (last_byte) begin
            step.status = trfs_pkg::VS_ERR;
            step.err    = trfs_pkg::ERR_OVERLONG;
        end else begin
            step.idx = idx_in + trfs_pkg::VIDX_W'(1);
        end
    end

endmodule

[design/trfs_core.sv]
module trfs_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  trfs_pkg::item_t     item,
    output trfs_pkg::result_t   result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_VARINT,
        PH_SIZED,
        PH_SKIP,
        PH_CLOSED
    } phase_t;

    phase_t          phase_reg, phase_next;
    trfs_pkg::vidx_t vidx_reg, vidx_next;
    logic [63:0]     acc_reg, acc_next;
    logic [31:0]     last_id_reg, last_id_next;
    logic [2:0]      enc_reg, enc_next;
    logic [31:0]     skip_reg, skip_next;
    logic [31:0]     left_reg, left_next;
    logic [3:0]      sticky_reg, sticky_next;

    trfs_pkg::vstep_t vs;
    logic [31:0]      left_dec;
    logic [31:0]      skip_dec;
    logic [60:0]      hdr_id;
    logic [63:0]      vval;
    logic [31:0]      begin_len;
    logic [3:0]       err;
    logic             hdr_done, pay_done, rec_done;
    logic [63:0]      val;

    trfs_varint u_varint (
        .idx_in  (vidx_reg),
        .acc_in  (acc_reg),
        .data_in (item.data_byte),
        .step    (vs)
    );

    assign left_dec  = (left_reg != '0) ? left_reg - 32'd1 : '0;
    assign skip_dec  = (skip_reg != '0) ? skip_reg - 32'd1 : '0;
    assign hdr_id    = vs.acc[63:3];
    assign begin_len = item.record_length & trfs_pkg::LEN_MASK;
    // zigzag decode for signed varints
    assign vval      = (enc_reg == trfs_pkg::ENC_VARSINT)
                       ? ((vs.acc >> 1) ^ {64{vs.acc[0]}}) : vs.acc;

    // Next state and result for the word in the input register
    always_comb begin
        phase_next   = phase_reg;
        vidx_next    = vidx_reg;
        acc_next     = acc_reg;
        last_id_next = last_id_reg;
        enc_next     = enc_reg;
        skip_next    = skip_reg;
        left_next    = left_reg;
        sticky_next  = sticky_reg;
        err          = trfs_pkg::ERR_NONE;
        hdr_done     = 1'b0;
        pay_done     = 1'b0;
        rec_done     = 1'b0;
        val          = '0;

        if (item.cmd == trfs_pkg::CMD_BEGIN) begin
            vidx_next    = '0;
            acc_next     = '0;
            last_id_next = '0;
            enc_next     = '0;
            skip_next    = '0;
            sticky_next  = trfs_pkg::ERR_NONE;
            left_next    = begin_len;
            if (begin_len == '0) begin
                phase_next = PH_CLOSED;
                rec_done   = 1'b1;
            end else begin
                phase_next = PH_HEADER;
            end
        end else if ((phase_reg != PH_IDLE) && (phase_reg != PH_CLOSED)) begin
            left_next = left_dec;
            unique case (phase_reg)
                PH_HEADER: begin
                    acc_next  = vs.acc;
                    vidx_next = vs.idx;
                    if (vs.status == trfs_pkg::VS_ERR) begin
                        err = vs.err;
                    end else if (vs.status == trfs_pkg::VS_DONE) begin
                        acc_next  = '0;
                        vidx_next = '0;
                        if (hdr_id == '0) begin
                            err = trfs_pkg::ERR_ID_ZERO;
                        end else if (hdr_id[60:32] != '0) begin
                            err = trfs_pkg::ERR_ID_WIDE;
                        end else if (hdr_id[31:0] <= last_id_reg) begin
                            err = trfs_pkg::ERR_ID_ORDER;
                        end else begin
                            last_id_next = hdr_id[31:0];
                            enc_next     = vs.acc[2:0];
                            hdr_done     = 1'b1;
                            if ((vs.acc[2:0] == trfs_pkg::ENC_VARUINT) ||
                                (vs.acc[2:0] == trfs_pkg::ENC_VARSINT)) begin
                                phase_next = PH_VARINT;
                            end else if (vs.acc[2:0] == trfs_pkg::ENC_SIZED) begin
                                phase_next = PH_SIZED;
                            end else begin
                                skip_next  = 32'(trfs_pkg::fixed_len(vs.acc[2:0]));
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end
                PH_VARINT: begin
                    acc_next  = vs.acc;
                    vidx_next = vs.idx;
                    if (vs.status == trfs_pkg::VS_ERR) begin
                        err = vs.err;
                    end else if (vs.status == trfs_pkg::VS_DONE) begin
                        val        = vval;
                        pay_done   = 1'b1;
                        acc_next   = '0;
                        vidx_next  = '0;
                        phase_next = PH_HEADER;
                    end
                end
                PH_SIZED: begin
                    acc_next  = vs.acc;
                    vidx_next = vs.idx;
                    if (vs.status == trfs_pkg::VS_ERR) begin
                        err = vs.err;
                    end else if (vs.status == trfs_pkg::VS_DONE) begin
                        acc_next  = '0;
                        vidx_next = '0;
                        val       = vs.acc;
                        if ((vs.acc[63:32] != '0) || (vs.acc[31:0] > left_dec)) begin
                            err = trfs_pkg::ERR_SIZED_PAST;
                        end else if (vs.acc[31:0] == '0) begin
                            pay_done   = 1'b1;
                            phase_next = PH_HEADER;
                        end else begin
                            skip_next  = vs.acc[31:0];
                            phase_next = PH_SKIP;
                        end
                    end
                end
                default: begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) begin
                        pay_done   = 1'b1;
                        phase_next = PH_HEADER;
                    end
                end
            endcase

            // last byte of the record must land on a field boundary
            if ((err == trfs_pkg::ERR_NONE) && (left_dec == '0)) begin
                if ((phase_next == PH_HEADER) && (vidx_next == '0)) begin
                    rec_done   = 1'b1;
                    phase_next = PH_CLOSED;
                end else begin
                    err = trfs_pkg::ERR_TRUNCATED;
                end
            end

            // error: record closed until next begin
            if (err != trfs_pkg::ERR_NONE) begin
                sticky_next = err;
                phase_next  = PH_IDLE;
                acc_next    = '0;
                vidx_next   = '0;
                skip_next   = '0;
                hdr_done    = 1'b0;
                pay_done    = 1'b0;
                val         = '0;
            end
        end

        result.header_done  = hdr_done;
        result.cur_id       = last_id_next;
        result.encoding     = enc_next;
        result.payload_done = pay_done;
        result.value        = val;
        result.record_done  = rec_done;
        result.error_code   = sticky_next;
    end

    // Scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            vidx_reg    <= '0;
            acc_reg     <= '0;
            last_id_reg <= '0;
            enc_reg     <= '0;
            skip_reg    <= '0;
            left_reg    <= '0;
            sticky_reg  <= trfs_pkg::ERR_NONE;
        end else if (fire) begin
            phase_reg   <= phase_next;
            vidx_reg    <= vidx_next;
            acc_reg     <= acc_next;
            last_id_reg <= last_id_next;
            enc_reg     <= enc_next;
            skip_reg    <= skip_next;
            left_reg    <= left_next;
            sticky_reg  <= sticky_next;
        end
    end

endmodule
